### src/pspc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspc_pkg
// Shared widths, register indexes, angle constants and the control struct
// of the pie sector pixel classifier.
// ----------------------------------------------------------------------------
package pspc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int RADIUS_BITS    = 11;
  localparam int R2_BITS        = 2 * RADIUS_BITS;
  localparam int PCT_BITS       = 7;
  localparam int COLOR_BITS     = 32;
  localparam int ANGLE_BITS     = 9;
  localparam int QUO_BITS       = 6;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_DISC_RADIUS = 3'd2,
    REG_USED_PCT    = 3'd3,
    REG_TAKEN_ARGB  = 3'd4,
    REG_SPARE_ARGB  = 3'd5
  } cfg_reg_e;

  localparam logic [QUO_BITS-1:0]   SECTOR_SCALE = 6'd45;
  localparam logic [ANGLE_BITS-1:0] RIGHT_ANGLE  = 9'd90;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN    = 9'd180;
  localparam logic [ANGLE_BITS-1:0] FULL_TURN    = 9'd360;
  localparam logic [PCT_BITS-1:0]   PCT_FULL     = 7'd100;

  // percent * 360 / 100 taken as percent * 18 / 5, the fifth by reciprocal
  localparam int DEG_PER_PCT_X5 = 360 / 20;
  localparam int DIV5_SHIFT     = 14;
  localparam int DIV5_RECIP     = ((1 << DIV5_SHIFT) + 4) / 5;
  localparam int PROD_BITS      = 11;
  localparam int SCALED_BITS    = PROD_BITS + 12;

  typedef struct packed {
    logic dx_neg;
    logic dy_pos;
    logic swap;
    logic zero;
    logic covered;
  } ctl_t;

  function automatic logic [ANGLE_BITS-1:0] sector_limit(input logic [PCT_BITS-1:0] pct);
    logic [PCT_BITS-1:0]    p;
    logic [PROD_BITS-1:0]   x;
    logic [SCALED_BITS-1:0] m;
    p = (pct > PCT_FULL) ? PCT_FULL : pct;
    x = PROD_BITS'(p) * PROD_BITS'(DEG_PER_PCT_X5);
    m = SCALED_BITS'(x) * SCALED_BITS'(DIV5_RECIP);
    return m[DIV5_SHIFT +: ANGLE_BITS];
  endfunction

endpackage

### src/pspc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspc_if
// Pixel input and classification result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pspc_pix_if #(
  parameter int COORD_BITS = pspc_pkg::COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface pspc_res_if ();
  logic                            valid;
  logic                            ready;
  logic                            covered;
  logic                            in_used_sector;
  logic [pspc_pkg::ANGLE_BITS-1:0] angle_degrees;
  logic [pspc_pkg::COLOR_BITS-1:0] pixel_color;

  modport source (output valid, output covered, output in_used_sector,
                  output angle_degrees, output pixel_color, input ready);
  modport sink   (input valid, input covered, input in_used_sector,
                  input angle_degrees, input pixel_color, output ready);
endinterface

### src/pspc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspc_front
// Three pipeline stages: offsets from the centre, squares and octant ratio
// operands, then the disc coverage compare.
// ----------------------------------------------------------------------------
module pspc_front #(
  parameter int COORD_BITS = pspc_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [COORD_BITS-1:0]              pixel_x_i,
  input  logic [COORD_BITS-1:0]              pixel_y_i,
  input  logic [COORD_BITS-1:0]              center_x_i,
  input  logic [COORD_BITS-1:0]              center_y_i,
  input  logic [pspc_pkg::R2_BITS-1:0]       r2_i,
  input  logic                               radius_nz_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output pspc_pkg::ctl_t                     ctl_o,
  output logic [COORD_BITS+pspc_pkg::QUO_BITS-1:0] num_o,
  output logic [COORD_BITS-1:0]              den_o
);

  localparam int REM_BITS  = COORD_BITS + pspc_pkg::QUO_BITS;
  localparam int SQ_BITS   = 2 * COORD_BITS;
  localparam int DIST_BITS = SQ_BITS + 1;
  localparam int CMP_BITS  = (DIST_BITS > pspc_pkg::R2_BITS) ? DIST_BITS : pspc_pkg::R2_BITS;

  logic ld_a, ld_b, ld_c;

  // stage a: offsets and magnitudes
  logic                  a_v_q;
  logic [COORD_BITS-1:0] a_ax_q, a_ay_q, a_ax_d, a_ay_d;
  pspc_pkg::ctl_t        a_ctl_q, a_ctl_d;
  logic [COORD_BITS:0]   dx, dy, ndx, ndy;

  // stage b: squares and ratio operands
  logic                  b_v_q;
  logic [SQ_BITS-1:0]    b_sqx_q, b_sqy_q, b_sqx_d, b_sqy_d;
  logic [REM_BITS-1:0]   b_num_q, b_num_d;
  logic [COORD_BITS-1:0] b_den_q, b_den_d;
  pspc_pkg::ctl_t        b_ctl_q, b_ctl_d;
  logic [COORD_BITS-1:0] small_v;

  // stage c: coverage
  logic                  c_v_q;
  logic [REM_BITS-1:0]   c_num_q;
  logic [COORD_BITS-1:0] c_den_q;
  pspc_pkg::ctl_t        c_ctl_q, c_ctl_d;
  logic [DIST_BITS-1:0]  dist2;

  assign ld_c       = !c_v_q || out_ready_i;
  assign ld_b       = !b_v_q || ld_c;
  assign ld_a       = !a_v_q || ld_b;
  assign in_ready_o = ld_a;

  always_comb begin
    dx  = {1'b0, pixel_x_i} - {1'b0, center_x_i};
    dy  = {1'b0, pixel_y_i} - {1'b0, center_y_i};
    ndx = -dx;
    ndy = -dy;
    a_ay_d = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    a_ax_d = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    a_ctl_d         = '0;
    a_ctl_d.dx_neg  = dx[COORD_BITS];
    a_ctl_d.dy_pos  = !dy[COORD_BITS] && (dy != '0);
  end

  always_comb begin
    b_sqx_d      = SQ_BITS'(a_ay_q) * SQ_BITS'(a_ay_q);
    b_sqy_d      = SQ_BITS'(a_ax_q) * SQ_BITS'(a_ax_q);
    b_ctl_d      = a_ctl_q;
    b_ctl_d.swap = a_ax_q > a_ay_q;
    b_ctl_d.zero = (a_ax_q == '0) && (a_ay_q == '0);
    small_v      = b_ctl_d.swap ? a_ay_q : a_ax_q;
    b_den_d      = b_ctl_d.swap ? a_ax_q : a_ay_q;
    b_num_d      = REM_BITS'(small_v) * REM_BITS'(pspc_pkg::SECTOR_SCALE);
  end

  always_comb begin
    dist2           = DIST_BITS'(b_sqx_q) + DIST_BITS'(b_sqy_q);
    c_ctl_d         = b_ctl_q;
    c_ctl_d.covered = radius_nz_i && (CMP_BITS'(dist2) <= CMP_BITS'(r2_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (ld_a) begin
        a_v_q <= in_valid_i;
      end
      if (ld_b) begin
        b_v_q <= a_v_q;
      end
      if (ld_c) begin
        c_v_q <= b_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_a && in_valid_i) begin
      a_ax_q  <= a_ax_d;
      a_ay_q  <= a_ay_d;
      a_ctl_q <= a_ctl_d;
    end
    if (ld_b && a_v_q) begin
      b_sqx_q <= b_sqx_d;
      b_sqy_q <= b_sqy_d;
      b_num_q <= b_num_d;
      b_den_q <= b_den_d;
      b_ctl_q <= b_ctl_d;
    end
    if (ld_c && b_v_q) begin
      c_num_q <= b_num_q;
      c_den_q <= b_den_q;
      c_ctl_q <= c_ctl_d;
    end
  end

  assign out_valid_o = c_v_q;
  assign ctl_o       = c_ctl_q;
  assign num_o       = c_num_q;
  assign den_o       = c_den_q;

endmodule

### src/pspc_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspc_div_stage
// One registered stage of the restoring divider, two quotient bits.
// ----------------------------------------------------------------------------
module pspc_div_stage #(
  parameter int COORD_BITS = pspc_pkg::COORD_BITS_DEF,
  parameter int BIT_HI     = pspc_pkg::QUO_BITS - 1
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  pspc_pkg::ctl_t                           ctl_i,
  input  logic [COORD_BITS+pspc_pkg::QUO_BITS-1:0] rem_i,
  input  logic [COORD_BITS-1:0]                    den_i,
  input  logic [pspc_pkg::QUO_BITS-1:0]            quo_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output pspc_pkg::ctl_t                           ctl_o,
  output logic [COORD_BITS+pspc_pkg::QUO_BITS-1:0] rem_o,
  output logic [COORD_BITS-1:0]                    den_o,
  output logic [pspc_pkg::QUO_BITS-1:0]            quo_o
);

  localparam int REM_BITS = COORD_BITS + pspc_pkg::QUO_BITS;

  logic                          v_q, ld;
  pspc_pkg::ctl_t                ctl_q;
  logic [REM_BITS-1:0]           rem_q, rem_d, rem_mid, sub_hi, sub_lo;
  logic [COORD_BITS-1:0]         den_q;
  logic [pspc_pkg::QUO_BITS-1:0] quo_q, quo_d;
  logic                          take_hi, take_lo;

  assign ld         = !v_q || out_ready_i;
  assign in_ready_o = ld;

  always_comb begin
    sub_hi          = REM_BITS'(den_i) << BIT_HI;
    sub_lo          = REM_BITS'(den_i) << (BIT_HI - 1);
    take_hi         = rem_i >= sub_hi;
    rem_mid         = take_hi ? (rem_i - sub_hi) : rem_i;
    take_lo         = rem_mid >= sub_lo;
    rem_d           = take_lo ? (rem_mid - sub_lo) : rem_mid;
    quo_d           = quo_i;
    quo_d[BIT_HI]   = take_hi;
    quo_d[BIT_HI-1] = take_lo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ld) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld && in_valid_i) begin
      ctl_q <= ctl_i;
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= quo_d;
    end
  end

  assign out_valid_o = v_q;
  assign ctl_o       = ctl_q;
  assign rem_o       = rem_q;
  assign den_o       = den_q;
  assign quo_o       = quo_q;

endmodule

### src/pspc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspc_back
// Quadrant folding of the octant angle, sector decision, colour select and
// the output register.
// ----------------------------------------------------------------------------
module pspc_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pspc_pkg::ctl_t                    ctl_i,
  input  logic [pspc_pkg::QUO_BITS-1:0]     quo_i,
  input  logic [pspc_pkg::ANGLE_BITS-1:0]   boundary_i,
  input  logic [pspc_pkg::COLOR_BITS-1:0]   taken_argb_i,
  input  logic [pspc_pkg::COLOR_BITS-1:0]   spare_argb_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              covered_o,
  output logic                              in_used_sector_o,
  output logic [pspc_pkg::ANGLE_BITS-1:0]   angle_degrees_o,
  output logic [pspc_pkg::COLOR_BITS-1:0]   pixel_color_o
);

  localparam int AB = pspc_pkg::ANGLE_BITS;

  logic                              v_q, ld;
  logic                              cov_q, used_q, used_d;
  logic [AB-1:0]                     ang_q, ang_d, base, half, full;
  logic [pspc_pkg::COLOR_BITS-1:0]   col_q, col_d;

  assign ld         = !v_q || out_ready_i;
  assign in_ready_o = ld;

  always_comb begin
    base = ctl_i.swap ? AB'(quo_i) : (pspc_pkg::RIGHT_ANGLE - AB'(quo_i));
    half = ctl_i.dy_pos ? (pspc_pkg::HALF_TURN - base) : base;
    full = ctl_i.dx_neg ? (pspc_pkg::FULL_TURN - half) : half;
    if (!ctl_i.covered || ctl_i.zero || (full == pspc_pkg::FULL_TURN)) begin
      ang_d = '0;
    end else begin
      ang_d = full;
    end
    used_d = ctl_i.covered && (ang_d < boundary_i);
    if (!ctl_i.covered) begin
      col_d = '0;
    end else begin
      col_d = used_d ? taken_argb_i : spare_argb_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ld) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld && in_valid_i) begin
      cov_q  <= ctl_i.covered;
      used_q <= used_d;
      ang_q  <= ang_d;
      col_q  <= col_d;
    end
  end

  assign out_valid_o      = v_q;
  assign covered_o        = cov_q;
  assign in_used_sector_o = used_q;
  assign angle_degrees_o  = ang_q;
  assign pixel_color_o    = col_q;

endmodule

### src/pie_sector_pixel_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pie_sector_pixel_classifier_core
// Classifies screen pixels against a configured pie chart: disc coverage,
// clockwise angle from north, used or free sector and its colour.
//
//   channel   dir  handshake      payload
//   pix_in    in   valid/ready    pixel_x, pixel_y
//   res_out   out  valid/ready    covered, in_used_sector, angle_degrees,
//                                 pixel_color
//   cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i (write only)
//
// one pixel per clock sustained while res_out is ready; 7 register stages
// from input to result: three front stages, three divider stages (two
// quotient bits each) and the output stage
// reset clears the settings and every valid bit, no warm-up pass
// a stalled output only holds the stages that are full; bubbles still fill
// ----------------------------------------------------------------------------
module pie_sector_pixel_classifier_core #(
  parameter int COORD_BITS = pspc_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  pspc_pix_if.sink                             pix_in,
  pspc_res_if.source                           res_out,
  input  logic                                 cfg_we_i,
  input  logic [pspc_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [pspc_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  localparam int REM_BITS   = COORD_BITS + pspc_pkg::QUO_BITS;
  localparam int DIV_STAGES = pspc_pkg::QUO_BITS / 2;

  logic [COORD_BITS-1:0]              center_x_q, center_y_q;
  logic [pspc_pkg::RADIUS_BITS-1:0]   radius_q;
  logic [pspc_pkg::PCT_BITS-1:0]      pct_q;
  logic [pspc_pkg::COLOR_BITS-1:0]    taken_argb_q, spare_argb_q;
  logic [pspc_pkg::R2_BITS-1:0]       r2_q;
  logic                               radius_nz_q;
  logic [pspc_pkg::ANGLE_BITS-1:0]    boundary_q;

  logic                               dv_valid [DIV_STAGES+1];
  logic                               dv_ready [DIV_STAGES+1];
  pspc_pkg::ctl_t                     dv_ctl   [DIV_STAGES+1];
  logic [REM_BITS-1:0]                dv_rem   [DIV_STAGES+1];
  logic [COORD_BITS-1:0]              dv_den   [DIV_STAGES+1];
  logic [pspc_pkg::QUO_BITS-1:0]      dv_quo   [DIV_STAGES+1];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= '0;
      center_y_q   <= '0;
      radius_q     <= '0;
      pct_q        <= '0;
      taken_argb_q <= '0;
      spare_argb_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pspc_pkg::REG_CENTER_X:    center_x_q   <= cfg_data_i[COORD_BITS-1:0];
        pspc_pkg::REG_CENTER_Y:    center_y_q   <= cfg_data_i[COORD_BITS-1:0];
        pspc_pkg::REG_DISC_RADIUS: radius_q     <= cfg_data_i[pspc_pkg::RADIUS_BITS-1:0];
        pspc_pkg::REG_USED_PCT:    pct_q        <= cfg_data_i[pspc_pkg::PCT_BITS-1:0];
        pspc_pkg::REG_TAKEN_ARGB:  taken_argb_q <= cfg_data_i[pspc_pkg::COLOR_BITS-1:0];
        pspc_pkg::REG_SPARE_ARGB:  spare_argb_q <= cfg_data_i[pspc_pkg::COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // derived settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_q        <= '0;
      radius_nz_q <= 1'b0;
      boundary_q  <= '0;
    end else begin
      r2_q        <= pspc_pkg::R2_BITS'(radius_q) * pspc_pkg::R2_BITS'(radius_q);
      radius_nz_q <= radius_q != '0;
      boundary_q  <= pspc_pkg::sector_limit(pct_q);
    end
  end

  pspc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_in.valid),
    .in_ready_o  (pix_in.ready),
    .pixel_x_i   (pix_in.pixel_x),
    .pixel_y_i   (pix_in.pixel_y),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .r2_i        (r2_q),
    .radius_nz_i (radius_nz_q),
    .out_valid_o (dv_valid[0]),
    .out_ready_i (dv_ready[0]),
    .ctl_o       (dv_ctl[0]),
    .num_o       (dv_rem[0]),
    .den_o       (dv_den[0])
  );

  assign dv_quo[0] = '0;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    pspc_div_stage #(
      .COORD_BITS (COORD_BITS),
      .BIT_HI     (pspc_pkg::QUO_BITS - 1 - 2 * g)
    ) u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dv_valid[g]),
      .in_ready_o  (dv_ready[g]),
      .ctl_i       (dv_ctl[g]),
      .rem_i       (dv_rem[g]),
      .den_i       (dv_den[g]),
      .quo_i       (dv_quo[g]),
      .out_valid_o (dv_valid[g+1]),
      .out_ready_i (dv_ready[g+1]),
      .ctl_o       (dv_ctl[g+1]),
      .rem_o       (dv_rem[g+1]),
      .den_o       (dv_den[g+1]),
      .quo_o       (dv_quo[g+1])
    );
  end

  pspc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (dv_valid[DIV_STAGES]),
    .in_ready_o       (dv_ready[DIV_STAGES]),
    .ctl_i            (dv_ctl[DIV_STAGES]),
    .quo_i            (dv_quo[DIV_STAGES]),
    .boundary_i       (boundary_q),
    .taken_argb_i     (taken_argb_q),
    .spare_argb_i     (spare_argb_q),
    .out_valid_o      (res_out.valid),
    .out_ready_i      (res_out.ready),
    .covered_o        (res_out.covered),
    .in_used_sector_o (res_out.in_used_sector),
    .angle_degrees_o  (res_out.angle_degrees),
    .pixel_color_o    (res_out.pixel_color)
  );

endmodule
